// ===== sv/sfr_pkg.sv =====
// Package for the MFM sector framer: item, result and command types,
// format constants and the CRC-16 CCITT byte update. No dependencies.
package sfr_pkg;

    localparam int TRACK_SIZE_DEF = 6400;
    localparam int POS_W          = 13;
    localparam int LEFT_W         = 11;
    localparam int STEP_W         = 6;
    localparam int CMD_DEPTH      = 4;

    localparam logic [15:0] CRC_PRESET = 16'hFFFF;
    localparam logic [15:0] CRC_POLY   = 16'h1021;
    localparam logic [7:0]  GAP_BYTE   = 8'h4E;
    localparam logic [7:0]  SYNC_BYTE  = 8'hA1;
    localparam logic [7:0]  ID_MARK    = 8'hFE;
    localparam logic [7:0]  DATA_MARK  = 8'hFB;
    localparam logic [LEFT_W-1:0] BASE_LEN = LEFT_W'(128);

    // header step map
    localparam logic [STEP_W-1:0] HS_SYNC1   = STEP_W'(12);
    localparam logic [STEP_W-1:0] HS_IDMARK  = STEP_W'(15);
    localparam logic [STEP_W-1:0] HS_CYL     = STEP_W'(16);
    localparam logic [STEP_W-1:0] HS_HEAD    = STEP_W'(17);
    localparam logic [STEP_W-1:0] HS_SECT    = STEP_W'(18);
    localparam logic [STEP_W-1:0] HS_SIZE    = STEP_W'(19);
    localparam logic [STEP_W-1:0] HS_CRC_HI  = STEP_W'(20);
    localparam logic [STEP_W-1:0] HS_CRC_LO  = STEP_W'(21);
    localparam logic [STEP_W-1:0] HS_GAP2    = STEP_W'(44);
    localparam logic [STEP_W-1:0] HS_SYNC2   = STEP_W'(56);
    localparam logic [STEP_W-1:0] HS_DMARK   = STEP_W'(59);
    localparam logic [STEP_W-1:0] HS_LAST    = STEP_W'(59);

    // data step map for the closing byte of a sector
    localparam logic [STEP_W-1:0] DS_CRC_HI  = STEP_W'(1);
    localparam logic [STEP_W-1:0] DS_CRC_LO  = STEP_W'(2);
    localparam logic [STEP_W-1:0] DS_LAST    = STEP_W'(42);

    typedef enum logic [1:0] {
        REQ_TRACK  = 2'd0,
        REQ_HEADER = 2'd1,
        REQ_DATA   = 2'd2,
        REQ_NONE   = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        CMD_TRACK  = 2'd0,
        CMD_HEADER = 2'd1,
        CMD_DATA   = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] cylinder;
        logic [7:0] head_number;
        logic [7:0] sector_number;
        logic [1:0] size_code;
        logic       bad_crc_mark;
        logic [7:0] data_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0]       out_byte;
        logic [POS_W-1:0] track_pos;
        logic             overflow;
        logic             last_of_run;
    } out_item_t;

    typedef struct packed {
        cmd_kind_t  kind;
        logic [7:0] cylinder;
        logic [7:0] head_number;
        logic [7:0] sector_number;
        logic [1:0] size_code;
        logic [7:0] data_byte;
        logic       close_sector;
        logic       bad_crc;
    } cmd_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15])
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

// ===== sv/sfr_front.sv =====
// Front end: classifies input items, tracks the open sector and its
// byte count, and issues commands. Depends on sfr_pkg.
module sfr_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic              full,
    input  sfr_pkg::in_item_t item,
    output logic              cmd_push,
    output sfr_pkg::cmd_t     cmd
);

    logic                           open_reg, open_next;
    logic                           bad_reg, bad_next;
    logic [sfr_pkg::LEFT_W-1:0]     left_reg, left_next;
    logic [sfr_pkg::LEFT_W-1:0]     left_dec;
    logic                           take;

    assign take     = push && !full;
    assign left_dec = left_reg - sfr_pkg::LEFT_W'(1);

    always_comb
    begin
        open_next = open_reg;
        bad_next  = bad_reg;
        left_next = left_reg;
        cmd_push  = 1'b0;
        cmd.kind          = sfr_pkg::CMD_TRACK;
        cmd.cylinder      = item.cylinder;
        cmd.head_number   = item.head_number;
        cmd.sector_number = item.sector_number;
        cmd.size_code     = item.size_code;
        cmd.data_byte     = item.data_byte;
        cmd.close_sector  = 1'b0;
        cmd.bad_crc       = bad_reg;
        if (take)
        begin
            unique case (sfr_pkg::req_t'(item.req_type))
                sfr_pkg::REQ_TRACK:
                begin
                    cmd_push  = 1'b1;
                    cmd.kind  = sfr_pkg::CMD_TRACK;
                    open_next = 1'b0;
                    bad_next  = 1'b0;
                    left_next = '0;
                end
                sfr_pkg::REQ_HEADER:
                begin
                    cmd_push  = 1'b1;
                    cmd.kind  = sfr_pkg::CMD_HEADER;
                    open_next = 1'b1;
                    bad_next  = item.bad_crc_mark;
                    left_next = sfr_pkg::BASE_LEN << item.size_code;
                end
                sfr_pkg::REQ_DATA:
                begin
                    if (open_reg)
                    begin
                        cmd_push         = 1'b1;
                        cmd.kind         = sfr_pkg::CMD_DATA;
                        cmd.close_sector = (left_dec == '0);
                        left_next        = left_dec;
                        if (left_dec == '0)
                        begin
                            open_next = 1'b0;
                            bad_next  = 1'b0;
                        end
                    end
                end
                sfr_pkg::REQ_NONE:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg <= 1'b0;
            bad_reg  <= 1'b0;
            left_reg <= '0;
        end
        else
        begin
            open_reg <= open_next;
            bad_reg  <= bad_next;
            left_reg <= left_next;
        end
    end

endmodule

// ===== sv/sfr_cmd_fifo.sv =====
// Command queue between front and back ends.
// Depends on sfr_pkg.
module sfr_cmd_fifo #(
    parameter int DEPTH = sfr_pkg::CMD_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  sfr_pkg::cmd_t wr_data,
    output logic          full,
    input  logic          rd_en,
    output sfr_pkg::cmd_t rd_data,
    output logic          empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    sfr_pkg::cmd_t    mem [DEPTH];
    sfr_pkg::cmd_t    rd_data_reg;
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic             do_wr, do_rd;

    assign full        = (count_reg == CNT_W'(DEPTH));
    assign empty       = (count_reg == '0);
    assign do_wr       = wr_en && !full;
    assign do_rd       = rd_en && !empty;
    assign rd_ptr_next = !do_rd ? rd_ptr_reg :
                         (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
    assign rd_data     = rd_data_reg;

    // head entry is kept registered; a write into an emptying queue bypasses
    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem[wr_ptr_reg] <= wr_data;
        if (do_wr && (wr_ptr_reg == rd_ptr_next))
            rd_data_reg <= wr_data;
        else
            rd_data_reg <= mem[rd_ptr_next];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            rd_ptr_reg <= rd_ptr_next;
            if (do_wr && !do_rd)
                count_reg <= count_reg + CNT_W'(1);
            else if (do_rd && !do_wr)
                count_reg <= count_reg - CNT_W'(1);
        end
    end

endmodule

// ===== sv/sfr_back.sv =====
// Back end: steps through each command, one track byte per cycle while the result
// slot is free, keeps the CRC and track position, and holds the result register.
// Depends on sfr_pkg.
module sfr_back #(
    parameter int TRACK_SIZE = sfr_pkg::TRACK_SIZE_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_empty,
    input  sfr_pkg::cmd_t      cmd,
    output logic               cmd_pop,
    output logic               empty,
    input  logic               pop,
    output sfr_pkg::out_item_t result
);

    localparam logic [sfr_pkg::POS_W-1:0] TRACK_END = sfr_pkg::POS_W'(TRACK_SIZE);

    logic [sfr_pkg::STEP_W-1:0] step_reg;
    logic [15:0]                crc_reg, crc_save_reg;
    logic [sfr_pkg::POS_W-1:0]  pos_reg;
    logic                       out_valid_reg;
    sfr_pkg::out_item_t         out_reg;

    logic                       slot_free, fire, emit, last_step, preset;
    logic [7:0]                 byte_sel;
    logic                       over;
    logic [15:0]                crc_in;

    assign slot_free = !out_valid_reg || pop;
    assign fire      = !cmd_empty && ((cmd.kind == sfr_pkg::CMD_TRACK) || slot_free);
    assign emit      = fire && (cmd.kind != sfr_pkg::CMD_TRACK);
    assign over      = (pos_reg >= TRACK_END);
    assign preset    = (cmd.kind == sfr_pkg::CMD_HEADER) &&
                       ((step_reg == sfr_pkg::HS_SYNC1) || (step_reg == sfr_pkg::HS_SYNC2));
    assign crc_in    = preset ? sfr_pkg::CRC_PRESET : crc_reg;

    always_comb
    begin
        byte_sel  = sfr_pkg::GAP_BYTE;
        last_step = 1'b1;
        unique case (cmd.kind)
            sfr_pkg::CMD_HEADER:
            begin
                last_step = (step_reg == sfr_pkg::HS_LAST);
                priority if (step_reg < sfr_pkg::HS_SYNC1)
                    byte_sel = 8'h00;
                else if (step_reg < sfr_pkg::HS_IDMARK)
                    byte_sel = sfr_pkg::SYNC_BYTE;
                else if (step_reg == sfr_pkg::HS_IDMARK)
                    byte_sel = sfr_pkg::ID_MARK;
                else if (step_reg == sfr_pkg::HS_CYL)
                    byte_sel = cmd.cylinder;
                else if (step_reg == sfr_pkg::HS_HEAD)
                    byte_sel = cmd.head_number;
                else if (step_reg == sfr_pkg::HS_SECT)
                    byte_sel = cmd.sector_number;
                else if (step_reg == sfr_pkg::HS_SIZE)
                    byte_sel = {6'd0, cmd.size_code};
                else if (step_reg == sfr_pkg::HS_CRC_HI)
                    byte_sel = crc_reg[15:8];
                else if (step_reg == sfr_pkg::HS_CRC_LO)
                    byte_sel = crc_save_reg[7:0];
                else if (step_reg < sfr_pkg::HS_GAP2)
                    byte_sel = sfr_pkg::GAP_BYTE;
                else if (step_reg < sfr_pkg::HS_SYNC2)
                    byte_sel = 8'h00;
                else if (step_reg < sfr_pkg::HS_DMARK)
                    byte_sel = sfr_pkg::SYNC_BYTE;
                else
                    byte_sel = sfr_pkg::DATA_MARK;
            end
            sfr_pkg::CMD_DATA:
            begin
                last_step = cmd.close_sector ? (step_reg == sfr_pkg::DS_LAST) : 1'b1;
                priority if (step_reg == '0)
                    byte_sel = cmd.data_byte;
                else if (step_reg == sfr_pkg::DS_CRC_HI)
                    byte_sel = cmd.bad_crc ? 8'h00 : crc_reg[15:8];
                else if (step_reg == sfr_pkg::DS_CRC_LO)
                    byte_sel = cmd.bad_crc ? 8'h00 : crc_save_reg[7:0];
                else
                    byte_sel = sfr_pkg::GAP_BYTE;
            end
            default:
            begin
                byte_sel  = 8'h00;
                last_step = 1'b1;
            end
        endcase
    end

    assign cmd_pop = fire && last_step;
    assign empty   = !out_valid_reg;
    assign result  = out_reg;

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_reg.out_byte    <= byte_sel;
            out_reg.track_pos   <= over ? TRACK_END : pos_reg;
            out_reg.overflow    <= over;
            out_reg.last_of_run <= last_step;
            crc_save_reg        <= crc_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= '0;
            crc_reg       <= sfr_pkg::CRC_PRESET;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
                step_reg <= last_step ? '0 : step_reg + sfr_pkg::STEP_W'(1);
            if (fire && (cmd.kind == sfr_pkg::CMD_TRACK))
                pos_reg <= '0;
            else if (emit && !over)
                pos_reg <= pos_reg + sfr_pkg::POS_W'(1);
            if (emit)
                crc_reg <= sfr_pkg::crc_byte(crc_in, byte_sel);
            if (emit)
                out_valid_reg <= 1'b1;
            else if (pop)
                out_valid_reg <= 1'b0;
        end
    end

endmodule

// ===== sv/mfm_sector_framer.sv =====
// Top level of the MFM sector framer: front end, command queue, back end.
// Depends on sfr_pkg, sfr_front, sfr_cmd_fifo, sfr_back.
//
//   channel  | handshake   | payload
//   ---------+-------------+---------------------------
//   item     | push / full | sfr_pkg::in_item_t  item
//   result   | empty / pop | sfr_pkg::out_item_t result
//
// One track byte leaves per cycle while results are popped. A data byte gives its byte;
// a closing data byte adds CRC and tail gap; a sector header, sync fields, ID, gap and
// data mark; a track start, no result. The back-end byte sequencer sets that rate;
// items enter at one per cycle until the 4-entry command queue fills. Reset clears
// position and sector state, presets the CRC. A held result (pop low) stalls byte output.
module mfm_sector_framer #(
    parameter int TRACK_SIZE = sfr_pkg::TRACK_SIZE_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  sfr_pkg::in_item_t  item,
    output logic               empty,
    input  logic               pop,
    output sfr_pkg::out_item_t result
);

    logic          cmd_wr, cmd_rd, cmd_empty;
    sfr_pkg::cmd_t cmd_in, cmd_out;

    sfr_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .item     (item),
        .cmd_push (cmd_wr),
        .cmd      (cmd_in)
    );

    sfr_cmd_fifo #(
        .DEPTH (sfr_pkg::CMD_DEPTH)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmd_wr),
        .wr_data (cmd_in),
        .full    (full),
        .rd_en   (cmd_rd),
        .rd_data (cmd_out),
        .empty   (cmd_empty)
    );

    sfr_back #(
        .TRACK_SIZE (TRACK_SIZE)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_empty (cmd_empty),
        .cmd       (cmd_out),
        .cmd_pop   (cmd_rd),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

endmodule

// ===== bench/tb.sv =====
// Testbench for mfm_sector_framer: a directed table, a random mix, a header burst
// and two closed sectors, the second into overflow, all checked against an in-bench predictor.
// Depends on sfr_pkg and mfm_sector_framer.
`timescale 1ns / 1ps

module tb;

    localparam int TRK         = sfr_pkg::TRACK_SIZE_DEF;
    localparam int PRE_LEN     = 12;
    localparam int ID_GAP_LEN  = 22;
    localparam int TAIL_LEN    = 40;
    localparam int MIX_ITEMS   = 20;
    localparam int CLOSE_ROOM  = 360;
    localparam int HOLD_AT     = 1500;
    localparam int HOLD_LEN    = 400;
    localparam int DRAIN_WAIT  = 64;
    localparam int STALL_LIMIT = 3000;

    typedef struct {
        sfr_pkg::in_item_t         it;
        bit                        typed;
        int                        n;
        logic [7:0]                b0;
        logic [sfr_pkg::POS_W-1:0] p0;
    } row_t;

    logic               clk   = 1'b0;
    logic               rst_n = 1'b0;
    logic               push  = 1'b0;
    logic               pop   = 1'b0;
    logic               full;
    logic               empty;
    sfr_pkg::in_item_t  item  = '0;
    sfr_pkg::out_item_t result;

    // predictor state
    logic [15:0]                crc_acc   = sfr_pkg::CRC_PRESET;
    logic [sfr_pkg::POS_W-1:0]  next_pos  = '0;
    logic [sfr_pkg::LEFT_W-1:0] data_left = '0;
    logic                       sect_open = 1'b0;
    logic                       bad_latch = 1'b0;
    sfr_pkg::out_item_t         track_q[$];

    int                 errors      = 0;
    int                 n_sent      = 0;
    int                 n_popped    = 0;
    int                 idle_cycles = 0;
    int                 run_len     = 0;
    sfr_pkg::out_item_t run_head;
    bit                 tx_fast     = 1'b0;
    bit                 rx_fast     = 1'b0;
    row_t               dir_tab[$];

    mfm_sector_framer dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    always
    begin
        #5;
        clk = ~clk;
    end

    function automatic logic [15:0] crc_step(input logic [15:0] c, input logic [7:0] b);
        logic fb;
        for (int i = 7; i >= 0; i--)
        begin
            fb = c[15] ^ b[i];
            c = {c[14:0], 1'b0} ^ (fb ? sfr_pkg::CRC_POLY : 16'h0000);
        end
        return c;
    endfunction

    function automatic void put_byte(input logic [7:0] b);
        sfr_pkg::out_item_t r;
        r.out_byte    = b;
        r.overflow    = (next_pos >= TRK);
        r.track_pos   = r.overflow ? sfr_pkg::POS_W'(TRK) : next_pos;
        r.last_of_run = 1'b0;
        if (!r.overflow)
            next_pos = next_pos + sfr_pkg::POS_W'(1);
        crc_acc = crc_step(crc_acc, b);
        track_q.push_back(r);
    endfunction

    function automatic void put_run(input int n, input logic [7:0] b);
        for (int i = 0; i < n; i++)
            put_byte(b);
    endfunction

    function automatic void put_mark(input logic [7:0] m);
        crc_acc = sfr_pkg::CRC_PRESET;
        put_run(3, sfr_pkg::SYNC_BYTE);
        put_byte(m);
    endfunction

    function automatic void put_crc();
        logic [15:0] c;
        c = crc_acc;
        put_byte(c[15:8]);
        put_byte(c[7:0]);
    endfunction

    // expected track bytes for one item; returns their count and the first one
    function automatic int frame_item(input sfr_pkg::in_item_t x,
                                      output sfr_pkg::out_item_t head);
        int                 base;
        sfr_pkg::out_item_t r;
        base = track_q.size();
        case (sfr_pkg::req_t'(x.req_type))
            sfr_pkg::REQ_TRACK:
            begin
                next_pos  = '0;
                sect_open = 1'b0;
                data_left = '0;
                bad_latch = 1'b0;
            end
            sfr_pkg::REQ_HEADER:
            begin
                put_run(PRE_LEN, 8'h00);
                put_mark(sfr_pkg::ID_MARK);
                put_byte(x.cylinder);
                put_byte(x.head_number);
                put_byte(x.sector_number);
                put_byte({6'b0, x.size_code});
                put_crc();
                put_run(ID_GAP_LEN, sfr_pkg::GAP_BYTE);
                put_run(PRE_LEN, 8'h00);
                put_mark(sfr_pkg::DATA_MARK);
                data_left = sfr_pkg::BASE_LEN << x.size_code;
                sect_open = 1'b1;
                bad_latch = x.bad_crc_mark;
            end
            sfr_pkg::REQ_DATA:
            begin
                if (sect_open)
                begin
                    put_byte(x.data_byte);
                    data_left = data_left - sfr_pkg::LEFT_W'(1);
                    if (data_left == '0)
                    begin
                        if (bad_latch)
                            put_run(2, 8'h00);
                        else
                            put_crc();
                        put_run(TAIL_LEN, sfr_pkg::GAP_BYTE);
                        sect_open = 1'b0;
                        bad_latch = 1'b0;
                    end
                end
            end
            default:
            begin
            end
        endcase
        head = '0;
        if (track_q.size() > base)
        begin
            r = track_q.pop_back();
            r.last_of_run = 1'b1;
            track_q.push_back(r);
            head = track_q[base];
        end
        return track_q.size() - base;
    endfunction

    function automatic void flag(input string what, input sfr_pkg::out_item_t e,
                                 input sfr_pkg::out_item_t a);
        errors++;
        if (errors <= 10)
            $display("%0t %s: exp %02h @%0d ovf %0b last %0b, got %02h @%0d ovf %0b last %0b",
                     $time, what, e.out_byte, e.track_pos, e.overflow, e.last_of_run,
                     a.out_byte, a.track_pos, a.overflow, a.last_of_run);
    endfunction

    function automatic sfr_pkg::in_item_t mk(input sfr_pkg::req_t kind,
                                             input logic [7:0] cyl, hd, sec,
                                             input logic [1:0] sz, input logic bad,
                                             input logic [7:0] dat);
        sfr_pkg::in_item_t x;
        x.req_type      = kind;
        x.cylinder      = cyl;
        x.head_number   = hd;
        x.sector_number = sec;
        x.size_code     = sz;
        x.bad_crc_mark  = bad;
        x.data_byte     = dat;
        return x;
    endfunction

    function automatic sfr_pkg::in_item_t rand_item(input sfr_pkg::req_t kind);
        return mk(kind, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)),
                  1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
    endfunction

    function automatic void add_row(input sfr_pkg::in_item_t it, input bit typed,
                                    input int n, input logic [7:0] b0, input int p0);
        dir_tab.push_back(row_t'{it, typed, n, b0, sfr_pkg::POS_W'(p0)});
    endfunction

    task automatic send_item(input sfr_pkg::in_item_t x);
        int gap;
        if ($urandom_range(0, 39) == 0)
            tx_fast = !tx_fast;
        gap = tx_fast ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        push <= 1'b1;
        item <= x;
        @(posedge clk);
        while (full)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_sector(input sfr_pkg::in_item_t h, input int n_data);
        send_item(h);
        for (int i = 0; i < n_data; i++)
            send_item(rand_item(sfr_pkg::REQ_DATA));
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        do
            @(negedge clk);
        while (track_q.size() != 0);
    endtask

    // monitor: predict on item acceptance, check on result acceptance, watchdog
    always @(posedge clk)
    begin
        sfr_pkg::out_item_t e;
        if (rst_n)
        begin
            if (push && !full)
            begin
                run_len = frame_item(item, run_head);
                n_sent++;
            end
            if (pop && !empty)
            begin
                n_popped++;
                if (track_q.size() == 0)
                    flag("no byte expected", '0, result);
                else
                begin
                    e = track_q.pop_front();
                    if (result.out_byte !== e.out_byte || result.track_pos !== e.track_pos ||
                        result.overflow !== e.overflow || result.last_of_run !== e.last_of_run)
                        flag("mismatch", e, result);
                end
            end
            if ((push && !full) || (pop && !empty))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // result side
    initial
    begin
        int gap;
        bit held;
        held = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (!held && n_popped >= HOLD_AT)
            begin
                held = 1'b1;
                pop <= 1'b0;
                repeat (HOLD_LEN) @(negedge clk);
            end
            if ($urandom_range(0, 39) == 0)
                rx_fast = !rx_fast;
            gap = rx_fast ? 0 : $urandom_range(0, 6);
            if (gap > 0)
            begin
                pop <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            pop <= 1'b1;
            @(posedge clk);
            while (empty)
                @(posedge clk);
            @(negedge clk);
        end
    end

    // item side
    initial
    begin
        sfr_pkg::in_item_t h;
        int                start;

        add_row(mk(sfr_pkg::REQ_DATA,   8'h00, 8'h00, 8'h00, 2'd0, 1'b0, 8'hFF), 1, 0,  8'h00, 0);
        add_row(mk(sfr_pkg::REQ_NONE,   8'hFF, 8'hFF, 8'hFF, 2'd3, 1'b1, 8'hFF), 1, 0,  8'h00, 0);
        add_row(mk(sfr_pkg::REQ_TRACK,  8'h00, 8'h00, 8'h00, 2'd0, 1'b0, 8'h00), 1, 0,  8'h00, 0);
        add_row(mk(sfr_pkg::REQ_HEADER, 8'hFF, 8'hFF, 8'hFF, 2'd3, 1'b1, 8'h00), 1, 60, 8'h00, 0);
        add_row(mk(sfr_pkg::REQ_DATA,   8'h00, 8'h00, 8'h00, 2'd0, 1'b0, 8'h00), 1, 1,  8'h00, 60);
        add_row(mk(sfr_pkg::REQ_DATA,   8'h00, 8'h00, 8'h00, 2'd0, 1'b0, 8'hFF), 1, 1,  8'hFF, 61);
        add_row(mk(sfr_pkg::REQ_HEADER, 8'h00, 8'h00, 8'h00, 2'd0, 1'b0, 8'hFF), 1, 60, 8'h00, 62);
        add_row(mk(sfr_pkg::REQ_DATA,   8'h00, 8'h00, 8'h00, 2'd0, 1'b0, 8'h5A), 0, 0,  8'h00, 0);
        add_row(mk(sfr_pkg::REQ_TRACK,  8'hFF, 8'hFF, 8'hFF, 2'd3, 1'b1, 8'hFF), 1, 0,  8'h00, 0);
        add_row(mk(sfr_pkg::REQ_DATA,   8'h00, 8'h00, 8'h00, 2'd0, 1'b0, 8'hA5), 1, 0,  8'h00, 0);
        add_row(mk(sfr_pkg::REQ_HEADER, 8'h01, 8'h02, 8'h03, 2'd1, 1'b0, 8'h00), 1, 60, 8'h00, 0);
        add_row(mk(sfr_pkg::REQ_DATA,   8'h00, 8'h00, 8'h00, 2'd0, 1'b0, 8'h80), 0, 0,  8'h00, 0);
        add_row(mk(sfr_pkg::REQ_DATA,   8'h00, 8'h00, 8'h00, 2'd0, 1'b0, 8'h7F), 0, 0,  8'h00, 0);
        add_row(mk(sfr_pkg::REQ_HEADER, 8'h55, 8'hAA, 8'h0F, 2'd2, 1'b1, 8'h00), 0, 0,  8'h00, 0);
        add_row(mk(sfr_pkg::REQ_NONE,   8'h00, 8'h00, 8'h00, 2'd0, 1'b0, 8'h33), 1, 0,  8'h00, 0);
        add_row(mk(sfr_pkg::REQ_DATA,   8'h00, 8'h00, 8'h00, 2'd0, 1'b0, 8'h01), 0, 0,  8'h00, 0);
        add_row(mk(sfr_pkg::REQ_HEADER, 8'h80, 8'h7F, 8'hFE, 2'd1, 1'b1, 8'h80), 0, 0,  8'h00, 0);
        add_row(mk(sfr_pkg::REQ_TRACK,  8'h00, 8'h00, 8'h00, 2'd0, 1'b0, 8'h00), 1, 0,  8'h00, 0);

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (dir_tab[i])
        begin
            send_item(dir_tab[i].it);
            if (dir_tab[i].typed && (run_len != dir_tab[i].n ||
                (run_len > 0 && (run_head.out_byte != dir_tab[i].b0 ||
                                 run_head.track_pos != dir_tab[i].p0))))
            begin
                errors++;
                if (errors <= 10)
                    $display("%0t row %0d: exp %0d bytes from %02h @%0d, got %0d from %02h @%0d",
                             $time, i, dir_tab[i].n, dir_tab[i].b0, dir_tab[i].p0,
                             run_len, run_head.out_byte, run_head.track_pos);
            end
        end
        wait_drained();

        // random mix of short sectors and single items
        send_item(rand_item(sfr_pkg::REQ_TRACK));
        start = n_sent;
        while (n_sent - start < MIX_ITEMS)
        begin
            if ($urandom_range(0, 9) < 4)
                send_sector(rand_item(sfr_pkg::REQ_HEADER), int'($urandom_range(0, 12)));
            else
                send_item(rand_item(sfr_pkg::req_t'($urandom_range(0, 3))));
        end

        // headers up to near the track end, a good sector, then a bad one into overflow
        while (next_pos < TRK - CLOSE_ROOM)
            send_item(rand_item(sfr_pkg::REQ_HEADER));
        h = rand_item(sfr_pkg::REQ_HEADER);
        h.size_code    = 2'd0;
        h.bad_crc_mark = 1'b0;
        send_sector(h, 128);
        h = rand_item(sfr_pkg::REQ_HEADER);
        h.size_code    = 2'd0;
        h.bad_crc_mark = 1'b1;
        send_sector(h, 128);
        send_item(rand_item(sfr_pkg::REQ_HEADER));
        send_item(rand_item(sfr_pkg::REQ_TRACK));

        push <= 1'b0;
        while (track_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (errors == 0 && track_q.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
